// ===== design/csr_edge_support_intersection_assert.svh =====
// Assertion helpers used by csei_walk.
`ifndef CSR_EDGE_SUPPORT_INTERSECTION_ASSERT_SVH
`define CSR_EDGE_SUPPORT_INTERSECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSEI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSEI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/csei_pkg.sv =====
package csei_pkg;

  localparam int MAX_VERTS = 1024;
  localparam int MAX_ADJ   = 16384;

  localparam int MODE_W = 2;
  localparam int SLOT_W = 14;
  localparam int VAL_W  = 15;
  localparam int VERT_W = 10;
  localparam int NB_W   = 10;
  localparam int SUP_W  = 10;
  localparam int LIM_W  = 11;

  localparam int OFS_DEPTH = MAX_VERTS + 1;
  localparam int OFS_AW    = $clog2(OFS_DEPTH);
  localparam int NB_AW     = $clog2(MAX_ADJ);
  // list pointers must hold MAX_ADJ itself
  localparam int PTR_W     = $clog2(MAX_ADJ + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_OFS   = 2'd0,
    MODE_NB    = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } csei_mode_t;

  typedef struct packed {
    csei_mode_t          mode;
    logic [SLOT_W-1:0]   slot;
    logic [VAL_W-1:0]    load_value;
    logic [VERT_W-1:0]   vert_u;
    logic [VERT_W-1:0]   vert_v;
  } csei_in_t;

  typedef struct packed {
    logic [VERT_W-1:0] edge_u;
    logic [VERT_W-1:0] edge_v;
    logic [SUP_W-1:0]  support;
  } csei_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFS_U,
    S_OFS_V,
    S_WALK,
    S_DONE
  } csei_state_t;

  // read addresses the walk engine drives into both stores
  typedef struct packed {
    logic [OFS_AW-1:0] ofs_addr0;
    logic [OFS_AW-1:0] ofs_addr1;
    logic [NB_AW-1:0]  nb_addr0;
    logic [NB_AW-1:0]  nb_addr1;
  } csei_raddr_t;

  typedef struct packed {
    logic idle;
    logic done;
  } csei_stat_t;

  function automatic logic [PTR_W-1:0] clamp_adj(input logic [VAL_W-1:0] x);
    logic [PTR_W-1:0] r;
    if (int'(x) > MAX_ADJ) r = PTR_W'(MAX_ADJ);
    else r = PTR_W'(x);
    return r;
  endfunction

endpackage

// ===== design/csei_ram.sv =====
module csei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== design/csei_walk.sv =====
`include "csr_edge_support_intersection_assert.svh"

module csei_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [csei_pkg::VERT_W-1:0] vert_u,
  input  logic [csei_pkg::VERT_W-1:0] vert_v,
  input  logic [csei_pkg::LIM_W-1:0]  vertex_limit,
  input  logic [csei_pkg::VAL_W-1:0]  ofs_rd0,
  input  logic [csei_pkg::VAL_W-1:0]  ofs_rd1,
  input  logic [csei_pkg::NB_W-1:0]   nb_rd0,
  input  logic [csei_pkg::NB_W-1:0]   nb_rd1,
  input  logic                        res_take,
  output csei_pkg::csei_raddr_t       raddr,
  output csei_pkg::csei_stat_t        stat,
  output csei_pkg::csei_out_t         res
);

  import csei_pkg::*;

  csei_state_t       state, state_next;
  logic [VERT_W-1:0] u, v;
  logic [PTR_W-1:0]  p1, e1, p2, e2;
  logic [PTR_W-1:0]  p1_next, e1_next, p2_next, e2_next;
  logic [SUP_W-1:0]  count, count_next;
  logic              stop;

  // either current entry at or above the limit ends the walk
  assign stop = (LIM_W'(nb_rd0) >= vertex_limit) || (LIM_W'(nb_rd1) >= vertex_limit);

  always_comb begin
    p1_next    = p1;
    e1_next    = e1;
    p2_next    = p2;
    e2_next    = e2;
    count_next = count;
    case (state)
      S_OFS_U: begin
        p1_next = clamp_adj(ofs_rd0);
        e1_next = clamp_adj(ofs_rd1);
      end
      S_OFS_V: begin
        p2_next    = clamp_adj(ofs_rd0);
        e2_next    = clamp_adj(ofs_rd1);
        count_next = '0;
      end
      S_WALK: begin
        if (!stop) begin
          if (nb_rd0 < nb_rd1) begin
            p1_next = p1 + 1'b1;
          end else if (nb_rd0 > nb_rd1) begin
            p2_next = p2 + 1'b1;
          end else begin
            p1_next = p1 + 1'b1;
            p2_next = p2 + 1'b1;
            if (count != {SUP_W{1'b1}}) count_next = count + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_OFS_U;
      S_OFS_U: state_next = S_OFS_V;
      S_OFS_V: state_next = (p1 < e1 && p2_next < e2_next) ? S_WALK : S_DONE;
      S_WALK:  state_next = (!stop && p1_next < e1 && p2_next < e2) ? S_WALK : S_DONE;
      S_DONE:  if (res_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // read issue: offsets of u then v, then one neighbor pair per merge step
  always_comb begin
    raddr.ofs_addr0 = OFS_AW'(u);
    raddr.ofs_addr1 = OFS_AW'(u) + 1'b1;
    if (state == S_IDLE) begin
      raddr.ofs_addr0 = OFS_AW'(vert_u);
      raddr.ofs_addr1 = OFS_AW'(vert_u) + 1'b1;
    end else if (state == S_OFS_U) begin
      raddr.ofs_addr0 = OFS_AW'(v);
      raddr.ofs_addr1 = OFS_AW'(v) + 1'b1;
    end
    raddr.nb_addr0 = p1_next[NB_AW-1:0];
    raddr.nb_addr1 = p2_next[NB_AW-1:0];
    stat.idle      = (state == S_IDLE);
    stat.done      = (state == S_DONE);
    res.edge_u     = u;
    res.edge_v     = v;
    res.support    = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      u <= vert_u;
      v <= vert_v;
    end
    p1    <= p1_next;
    e1    <= e1_next;
    p2    <= p2_next;
    e2    <= e2_next;
    count <= count_next;
  end

  `CSEI_ASSERT_NOW(a_walk_in_bounds, clk, rst, state == S_WALK, (p1 < e1) && (p2 < e2), "walk step outside list bounds")
  `CSEI_ASSERT_NEXT(a_walk_exit, clk, rst, state == S_WALK, state == S_WALK || state == S_DONE, "walk left to a bad state")
  `CSEI_ASSERT_NEXT(a_count_monotonic, clk, rst, state == S_WALK, count >= $past(count), "support count decreased")
  `CSEI_ASSERT_NEXT(a_done_holds, clk, rst, state == S_DONE && !res_take, state == S_DONE, "result dropped before taken")

endmodule

// ===== design/csr_edge_support_intersection.sv =====
// channel   dir  handshake            payload
// in        in   in_valid / in_stall   csei_in_t  (load offset, load neighbor, query)
// out       out  out_valid / out_stall csei_out_t (edge and its support)
// cfg       in   cfg_valid / cfg_ready vertex_limit write data
//
// A load item is accepted whenever the block is idle; a query holds the input through
// the offset reads and its merge steps, at most deg(u) + deg(v), until the output
// is free. The dual read port of the neighbor store sets one merge step per
// cycle; offsets of u then v come over the dual read port of the offset store.
// Reset clears control, holds off input and cfg, sets vertex_limit to 1024.
// A stalled output holds the finished query in its final state until taken.
module csr_edge_support_intersection (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  csei_pkg::csei_in_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output csei_pkg::csei_out_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [csei_pkg::LIM_W-1:0] cfg_data
);

  import csei_pkg::*;

  logic              in_fire, start, out_free;
  logic              ofs_we, nb_we;
  logic [LIM_W-1:0]  vertex_limit;
  logic [VAL_W-1:0]  ofs_rd0, ofs_rd1;
  logic [NB_W-1:0]   nb_rd0, nb_rd1;
  csei_raddr_t       raddr;
  csei_stat_t        stat;
  csei_out_t         res;

  assign in_stall  = rst || !stat.idle;
  assign in_fire   = in_valid && !in_stall;
  assign start     = in_fire && (in_item.mode == MODE_QUERY);
  assign ofs_we    = in_fire && (in_item.mode == MODE_OFS) && (int'(in_item.slot) <= MAX_VERTS);
  assign nb_we     = in_fire && (in_item.mode == MODE_NB) && (int'(in_item.slot) < MAX_ADJ);
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = !rst;

  csei_ram #(.WIDTH(VAL_W), .DEPTH(OFS_DEPTH)) u_ofs_ram (
    .clk    (clk),
    .we     (ofs_we),
    .waddr  (in_item.slot[OFS_AW-1:0]),
    .wdata  (in_item.load_value),
    .raddr0 (raddr.ofs_addr0),
    .raddr1 (raddr.ofs_addr1),
    .rdata0 (ofs_rd0),
    .rdata1 (ofs_rd1)
  );

  csei_ram #(.WIDTH(NB_W), .DEPTH(MAX_ADJ)) u_nb_ram (
    .clk    (clk),
    .we     (nb_we),
    .waddr  (in_item.slot[NB_AW-1:0]),
    .wdata  (in_item.load_value[NB_W-1:0]),
    .raddr0 (raddr.nb_addr0),
    .raddr1 (raddr.nb_addr1),
    .rdata0 (nb_rd0),
    .rdata1 (nb_rd1)
  );

  csei_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .vert_u       (in_item.vert_u),
    .vert_v       (in_item.vert_v),
    .vertex_limit (vertex_limit),
    .ofs_rd0      (ofs_rd0),
    .ofs_rd1      (ofs_rd1),
    .nb_rd0       (nb_rd0),
    .nb_rd1       (nb_rd1),
    .res_take     (out_free),
    .raddr        (raddr),
    .stat         (stat),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit <= LIM_W'(MAX_VERTS);
    end else if (cfg_valid && cfg_ready) begin
      vertex_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && out_free) begin
      out_item <= res;
    end
  end

endmodule
